/* hw/rtl/wtm_pkg.sv */
// Package for the wildcard track merge table: states, modes, codes and defaults.
package wtm_pkg;

  localparam int NVIEWS_DEF       = 8;
  localparam int NTRACKS_DEF      = 1024;
  localparam int FEATURE_BITS_DEF = 16;

  localparam logic [5:0] MIN_OVERLAP_RST = 6'd2;

  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 32;

  localparam logic [2:0] ST_MERGED   = 3'd0;
  localparam logic [2:0] ST_APPENDED = 3'd1;
  localparam logic [2:0] ST_INCONS   = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_CLEARED  = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MASK,
    S_CMP,
    S_DEC,
    S_WR,
    S_TMASK,
    S_END,
    S_OUT
  } state_e;

  typedef enum logic [2:0] {
    M_COPY,
    M_FIRST,
    M_ABSORB,
    M_APPEND,
    M_TAIL
  } mode_e;

endpackage

/* hw/rtl/wildcard_track_merge_table.sv */
// Top level of the wildcard track merge table: sequencer over one shared compare and copy unit.
// A clear goes straight to the output stage; a triplet scans each stored track, merges or moves
// tracks as it goes, moves the remaining tracks after an inconsistent pair, or appends itself,
// and then registers its result. Only one transaction is accepted at a time.
// Reset: the track count is cleared and the overlap threshold returns to 2; memories hold.
module wildcard_track_merge_table #(
  parameter int NVIEWS       = wtm_pkg::NVIEWS_DEF,
  parameter int NTRACKS      = wtm_pkg::NTRACKS_DEF,
  parameter int FEATURE_BITS = wtm_pkg::FEATURE_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // first_view[4:0], feature_a[20:5], feature_b[36:21], feature_c[52:37], zero pad
  input  logic [wtm_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // op[0]
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // track_slot[9:0], merge_count[20:10], tracks_held[31:21]
  output logic [wtm_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // status[2:0]
  output logic [2:0]                       m_axis_tuser,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [5:0]                       cfg_data_i
);
  import wtm_pkg::*;

  localparam int VW = $clog2(NVIEWS);
  localparam int RW = $clog2(NTRACKS);
  localparam int AW = RW + VW;
  localparam int TW = $clog2(NTRACKS + 1);
  localparam int CW = $clog2(NVIEWS + 1);
  localparam int FB = FEATURE_BITS;

  state_e state_q, state_d;
  mode_e  mode_q, mode_d;

  logic [CW-1:0]     vcnt_q, vcnt_d;
  logic [TW-1:0]     src_q, src_d, wr_q, wr_d, mdst_q, mdst_d, dst_q, dst_d;
  logic [TW-1:0]     brk_q, brk_d, total_q, total_d, cnt_q, cnt_d;
  logic [NVIEWS-1:0] imask_q, imask_d, mm_q, mm_d;
  logic              tok_q, tok_d, mok_q, mok_d;
  logic [1:0]        sh_q, sh_d;
  logic [FB-1:0]     ta_q, ta_d, tb_q, tb_d, tc_q, tc_d;
  logic [VW-1:0]     bv_q, bv_d;
  logic [5:0]        minov_q;
  logic [2:0]        rstat_q, rstat_d;
  logic [TW-1:0]     rslot_q, rslot_d, rcnt_q, rcnt_d;
  logic              ovalid_q;
  logic [2:0]        ostat_q;
  logic [OUT_TDATA_W-1:0] odata_q;

  logic              feat_we, mask_we;
  logic [AW-1:0]     feat_waddr, raddr_a, raddr_b;
  logic [FB-1:0]     feat_wdata, rdata_a, rdata_b;
  logic [RW-1:0]     mask_waddr;
  logic [NVIEWS-1:0] mask_wdata, mask_rdata;

  logic [VW-1:0]     pv;
  logic [VW:0]       pv_off;
  logic              tbit, ibit, mbit, match, vdone, out_free, in_acc;
  logic [FB-1:0]     tval;
  logic [NVIEWS-1:0] tmask;
  logic [4:0]        base_in;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign out_free      = !ovalid_q || m_axis_tready;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = ostat_q;

  // View under processing lags the read counter by one (registered memory read).
  assign pv     = VW'(vcnt_q - CW'(1));
  assign pv_off = {1'b0, pv} - {1'b0, bv_q};
  assign tbit   = ({1'b0, pv} >= {1'b0, bv_q}) && (pv_off <= (VW + 1)'(2));
  assign ibit   = imask_q[pv];
  assign mbit   = mm_q[pv];
  assign tmask  = NVIEWS'(3'b111) << bv_q;
  assign vdone  = (vcnt_q == CW'(NVIEWS));
  assign match  = tok_q && (6'(sh_q) >= minov_q);
  assign base_in = s_axis_tdata[4:0];

  always_comb begin
    case (pv_off[1:0])
      2'd0:    tval = ta_q;
      2'd1:    tval = tb_q;
      default: tval = tc_q;
    endcase
  end

  function automatic logic [TW-1:0] skip_gap(logic [TW-1:0] s, logic [TW-1:0] w,
                                             logic [TW-1:0] b);
    return (s == w) ? b : s;
  endfunction

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_acc) state_d = s_axis_tuser ? S_OUT : S_MASK;
      S_MASK:  state_d = (src_q >= total_q) ? S_END : S_CMP;
      S_CMP:   if (vdone) state_d = S_DEC;
      S_DEC: begin
        if (!match) state_d = (wr_q == src_q) ? S_MASK : S_WR;
        else if (cnt_q == '0 || mok_q) state_d = S_WR;
        else state_d = S_TMASK;
      end
      S_WR: begin
        if (vdone) begin
          case (mode_q)
            M_APPEND: state_d = S_OUT;
            M_TAIL:   state_d = S_TMASK;
            default:  state_d = S_MASK;
          endcase
        end
      end
      S_TMASK: state_d = (src_q >= total_q) ? S_OUT : S_WR;
      S_END: begin
        if (cnt_q == '0 && total_q < TW'(NTRACKS)) state_d = S_WR;
        else state_d = S_OUT;
      end
      S_OUT:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    mode_d  = mode_q;
    vcnt_d  = vcnt_q;
    src_d   = src_q;
    wr_d    = wr_q;
    mdst_d  = mdst_q;
    dst_d   = dst_q;
    brk_d   = brk_q;
    total_d = total_q;
    cnt_d   = cnt_q;
    imask_d = imask_q;
    mm_d    = mm_q;
    tok_d   = tok_q;
    mok_d   = mok_q;
    sh_d    = sh_q;
    ta_d    = ta_q;
    tb_d    = tb_q;
    tc_d    = tc_q;
    bv_d    = bv_q;
    rstat_d = rstat_q;
    rslot_d = rslot_q;
    rcnt_d  = rcnt_q;

    feat_we    = 1'b0;
    feat_waddr = {dst_q[RW-1:0], pv};
    feat_wdata = rdata_a;
    mask_we    = 1'b0;
    mask_waddr = dst_q[RW-1:0];
    mask_wdata = imask_q;
    raddr_a    = {src_q[RW-1:0], vcnt_q[VW-1:0]};
    raddr_b    = {mdst_q[RW-1:0], vcnt_q[VW-1:0]};

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          src_d = '0;
          wr_d  = '0;
          cnt_d = '0;
          ta_d  = FB'(s_axis_tdata[20:5]);
          tb_d  = FB'(s_axis_tdata[36:21]);
          tc_d  = FB'(s_axis_tdata[52:37]);
          bv_d  = (base_in > 5'(NVIEWS - 3)) ? VW'(NVIEWS - 3) : VW'(base_in);
          if (s_axis_tuser) begin
            total_d = '0;
            rstat_d = ST_CLEARED;
            rslot_d = '0;
            rcnt_d  = '0;
          end
        end
      end
      S_MASK: begin
        vcnt_d = '0;
        tok_d  = 1'b1;
        mok_d  = 1'b1;
        sh_d   = '0;
      end
      S_CMP: begin
        if (vcnt_q == '0) begin
          imask_d = mask_rdata;
        end else begin
          if (ibit && tbit) begin
            if (rdata_a != tval) tok_d = 1'b0;
            else sh_d = sh_q + 2'd1;
          end
          if (ibit && mbit && rdata_a != rdata_b) mok_d = 1'b0;
        end
        vcnt_d = vcnt_q + CW'(1);
      end
      S_DEC: begin
        vcnt_d = '0;
        dst_d  = wr_q;
        if (!match) begin
          mode_d = M_COPY;
          if (wr_q == src_q) begin
            src_d = src_q + TW'(1);
            wr_d  = wr_q + TW'(1);
          end
        end else if (cnt_q == '0) begin
          mode_d = M_FIRST;
          mdst_d = wr_q;
          mm_d   = imask_q | tmask;
          cnt_d  = TW'(1);
        end else if (mok_q) begin
          mode_d = M_ABSORB;
          dst_d  = mdst_q;
          cnt_d  = cnt_q + TW'(1);
        end else begin
          // Drop both tracks; close the gap left by the first match and this one.
          cnt_d = cnt_q + TW'(1);
          dst_d = mdst_q;
          brk_d = src_q + TW'(1);
          src_d = skip_gap(mdst_q + TW'(1), wr_q, src_q + TW'(1));
        end
      end
      S_WR: begin
        if (vcnt_q == '0 && mode_q == M_TAIL) imask_d = mask_rdata;
        if (vcnt_q != '0) begin
          case (mode_q)
            M_FIRST: begin
              feat_we    = 1'b1;
              feat_wdata = (tbit && !ibit) ? tval : rdata_a;
            end
            M_ABSORB: feat_we = !mbit && ibit;
            M_APPEND: begin
              feat_we    = 1'b1;
              feat_wdata = tbit ? tval : '0;
            end
            default:  feat_we = 1'b1;
          endcase
        end
        vcnt_d = vcnt_q + CW'(1);
        if (vdone) begin
          vcnt_d = '0;
          case (mode_q)
            M_COPY: begin
              mask_we = 1'b1;
              wr_d    = wr_q + TW'(1);
              src_d   = src_q + TW'(1);
            end
            M_FIRST: begin
              mask_we    = 1'b1;
              mask_wdata = imask_q | tmask;
              wr_d       = wr_q + TW'(1);
              src_d      = src_q + TW'(1);
            end
            M_ABSORB: begin
              mm_d  = mm_q | imask_q;
              src_d = src_q + TW'(1);
            end
            M_APPEND: begin
              mask_we    = 1'b1;
              mask_wdata = tmask;
              total_d    = total_q + TW'(1);
              rstat_d    = ST_APPENDED;
              rslot_d    = total_q;
              rcnt_d     = '0;
            end
            default: begin
              mask_we = 1'b1;
              dst_d   = dst_q + TW'(1);
              src_d   = skip_gap(src_q + TW'(1), wr_q, brk_q);
            end
          endcase
        end
      end
      S_TMASK: begin
        vcnt_d = '0;
        mode_d = M_TAIL;
        if (src_q >= total_q) begin
          total_d = dst_q;
          rstat_d = ST_INCONS;
          rslot_d = '0;
          rcnt_d  = cnt_q;
        end
      end
      S_END: begin
        vcnt_d = '0;
        if (cnt_q == '0) begin
          mode_d = M_APPEND;
          dst_d  = total_q;
          if (total_q >= TW'(NTRACKS)) begin
            rstat_d = ST_FULL;
            rslot_d = '0;
            rcnt_d  = '0;
          end
        end else begin
          mask_we    = 1'b1;
          mask_waddr = mdst_q[RW-1:0];
          mask_wdata = mm_q;
          total_d    = wr_q;
          rstat_d    = ST_MERGED;
          rslot_d    = mdst_q;
          rcnt_d     = cnt_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      total_q  <= '0;
      minov_q  <= MIN_OVERLAP_RST;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      if (cfg_valid_i) minov_q <= cfg_data_i;
      if (state_q == S_OUT && out_free) ovalid_q <= 1'b1;
      else if (m_axis_tready) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q  <= mode_d;
    vcnt_q  <= vcnt_d;
    src_q   <= src_d;
    wr_q    <= wr_d;
    mdst_q  <= mdst_d;
    dst_q   <= dst_d;
    brk_q   <= brk_d;
    cnt_q   <= cnt_d;
    imask_q <= imask_d;
    mm_q    <= mm_d;
    tok_q   <= tok_d;
    mok_q   <= mok_d;
    sh_q    <= sh_d;
    ta_q    <= ta_d;
    tb_q    <= tb_d;
    tc_q    <= tc_d;
    bv_q    <= bv_d;
    rstat_q <= rstat_d;
    rslot_q <= rslot_d;
    rcnt_q  <= rcnt_d;
    if (state_q == S_OUT && out_free) begin
      ostat_q <= rstat_q;
      odata_q <= {11'(total_q), 11'(rcnt_q), 10'(rslot_q)};
    end
  end

  wtm_store #(
    .NVIEWS       (NVIEWS),
    .NTRACKS      (NTRACKS),
    .FEATURE_BITS (FEATURE_BITS)
  ) u_store (
    .clk_i          (clk_i),
    .feat_we_i      (feat_we),
    .feat_waddr_i   (feat_waddr),
    .feat_wdata_i   (feat_wdata),
    .feat_raddr_a_i (raddr_a),
    .feat_raddr_b_i (raddr_b),
    .feat_rdata_a_o (rdata_a),
    .feat_rdata_b_o (rdata_b),
    .mask_we_i      (mask_we),
    .mask_waddr_i   (mask_waddr),
    .mask_wdata_i   (mask_wdata),
    .mask_raddr_i   (src_q[RW-1:0]),
    .mask_rdata_o   (mask_rdata)
  );

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= TW'(NTRACKS))
    else $error("track count above table size");

  a_wr_behind_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP || state_q == S_DEC) |-> (wr_q <= src_q))
    else $error("compaction write pointer ahead of scan");

  a_vcnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP || state_q == S_WR) |-> (vcnt_q <= CW'(NVIEWS)))
    else $error("view counter out of range");

  a_first_dst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WR && mode_q == M_FIRST) |-> (mdst_q == dst_q))
    else $error("first match written away from its slot");

endmodule

/* hw/rtl/wtm_store.sv */
// Track storage: feature memory with two read ports and per-track filled-view masks.
module wtm_store #(
  parameter int NVIEWS       = wtm_pkg::NVIEWS_DEF,
  parameter int NTRACKS      = wtm_pkg::NTRACKS_DEF,
  parameter int FEATURE_BITS = wtm_pkg::FEATURE_BITS_DEF,
  localparam int VW = $clog2(NVIEWS),
  localparam int RW = $clog2(NTRACKS),
  localparam int AW = RW + VW
) (
  input  logic                    clk_i,
  input  logic                    feat_we_i,
  input  logic [AW-1:0]           feat_waddr_i,
  input  logic [FEATURE_BITS-1:0] feat_wdata_i,
  input  logic [AW-1:0]           feat_raddr_a_i,
  input  logic [AW-1:0]           feat_raddr_b_i,
  output logic [FEATURE_BITS-1:0] feat_rdata_a_o,
  output logic [FEATURE_BITS-1:0] feat_rdata_b_o,
  input  logic                    mask_we_i,
  input  logic [RW-1:0]           mask_waddr_i,
  input  logic [NVIEWS-1:0]       mask_wdata_i,
  input  logic [RW-1:0]           mask_raddr_i,
  output logic [NVIEWS-1:0]       mask_rdata_o
);

  logic [FEATURE_BITS-1:0] feat_mem [NTRACKS * (2 ** VW)];
  logic [NVIEWS-1:0]       mask_mem [NTRACKS];

  always_ff @(posedge clk_i) begin
    if (feat_we_i) begin
      feat_mem[feat_waddr_i] <= feat_wdata_i;
    end
    feat_rdata_a_o <= feat_mem[feat_raddr_a_i];
    feat_rdata_b_o <= feat_mem[feat_raddr_b_i];
  end

  always_ff @(posedge clk_i) begin
    if (mask_we_i) begin
      mask_mem[mask_waddr_i] <= mask_wdata_i;
    end
    mask_rdata_o <= mask_mem[mask_raddr_i];
  end

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the wildcard track merge table.
`timescale 1ns / 100ps

module tb_top;
  import wtm_pkg::*;

  localparam int NV = NVIEWS_DEF;
  localparam int NT = NTRACKS_DEF;
  localparam int WATCHDOG_LIMIT = 400000;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  slot;
    logic [10:0] count;
    logic [10:0] held;
  } outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [2:0] m_axis_tuser;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [5:0] cfg_data_i = '0;

  wildcard_track_merge_table u_dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predictor state
  logic [15:0] trk_feat [NT][NV];
  logic [NV-1:0] trk_mask [NT];
  int unsigned trk_total;
  logic [5:0] overlap_min;

  outcome_t pending_outcomes[$];
  int errors = 0;
  bit stalls_on = 1'b1;
  int quiet_cycles = 0;
  int hold_cycles = 0;

  function automatic bit views_agree(input logic [15:0] fa[NV], input logic [NV-1:0] ma,
                                     input logic [15:0] fb[NV], input logic [NV-1:0] mb,
                                     output int shared);
    shared = 0;
    for (int v = 0; v < NV; v++)
      if (ma[v] && mb[v]) begin
        if (fa[v] != fb[v]) return 1'b0;
        shared++;
      end
    return 1'b1;
  endfunction

  task automatic drop_track(input int t);
    if (t >= trk_total) return;
    for (int k = t; k < trk_total - 1; k++) begin
      trk_feat[k] = trk_feat[k+1];
      trk_mask[k] = trk_mask[k+1];
    end
    trk_total--;
  endtask

  task automatic predict_merge(input bit op, input int bv_in, input logic [15:0] fa,
                               input logic [15:0] fb, input logic [15:0] fc,
                               output outcome_t res);
    logic [15:0] trip[NV];
    logic [NV-1:0] tmask;
    int bv, idx, cnt, first, sh;
    cnt = 0; first = 0;
    res = '0;
    if (op) begin
      trk_total = 0;
      res.status = ST_CLEARED;
      return;
    end
    bv = (bv_in > NV - 3) ? NV - 3 : bv_in;
    foreach (trip[v]) trip[v] = '0;
    trip[bv] = fa; trip[bv+1] = fb; trip[bv+2] = fc;
    tmask = NV'(7) << bv;
    idx = 0;
    while (idx < trk_total) begin
      if (!views_agree(trk_feat[idx], trk_mask[idx], trip, tmask, sh) || sh < overlap_min) begin
        idx++;
        continue;
      end
      if (cnt == 0) begin
        for (int v = 0; v < NV; v++)
          if (!trk_mask[idx][v] && tmask[v]) begin
            trk_feat[idx][v] = trip[v];
            trk_mask[idx][v] = 1'b1;
          end
        first = idx; cnt = 1; idx++;
      end else if (views_agree(trk_feat[idx], trk_mask[idx], trk_feat[first],
                               trk_mask[first], sh)) begin
        for (int v = 0; v < NV; v++)
          if (!trk_mask[first][v] && trk_mask[idx][v]) begin
            trk_feat[first][v] = trk_feat[idx][v];
            trk_mask[first][v] = 1'b1;
          end
        drop_track(idx);
        cnt++;
      end else begin
        cnt++;
        drop_track(idx);
        drop_track(first);
        res.status = ST_INCONS; res.count = 11'(cnt); res.held = 11'(trk_total);
        return;
      end
    end
    if (cnt == 0) begin
      if (trk_total >= NT) begin
        res.status = ST_FULL; res.held = 11'(trk_total);
        return;
      end
      trk_feat[trk_total] = trip;
      trk_mask[trk_total] = tmask;
      res.status = ST_APPENDED; res.slot = 10'(trk_total);
      trk_total++;
      res.held = 11'(trk_total);
      return;
    end
    res.status = ST_MERGED; res.slot = 10'(first); res.count = 11'(cnt);
    res.held = 11'(trk_total);
  endtask

  task automatic idle_burst();
    if (stalls_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
  endtask

  task automatic send_item(input bit op, input int bv, input logic [15:0] fa,
                           input logic [15:0] fb, input logic [15:0] fc);
    outcome_t res;
    idle_burst();
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {3'b0, fc, fb, fa, 5'(bv)};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_merge(op, bv, fa, fb, fc, res);
    pending_outcomes = {pending_outcomes, res};
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_overlap(input logic [5:0] val);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    overlap_min = val;
    cfg_valid_i <= 1'b0;
  endtask

  // Result checker with random back-pressure
  always @(posedge clk_i) begin
    outcome_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tuser, m_axis_tdata[9:0], m_axis_tdata[20:10], m_axis_tdata[31:21]};
        if (pending_outcomes.size() == 0) begin
          $error("unexpected result transaction %h", got);
          errors++;
        end else begin
          want = pending_outcomes.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d actual %0d", want.status, got.status); errors++;
          end
          if (got.slot !== want.slot) begin
            $error("track_slot: expected %0d actual %0d", want.slot, got.slot); errors++;
          end
          if (got.count !== want.count) begin
            $error("merge_count: expected %0d actual %0d", want.count, got.count); errors++;
          end
          if (got.held !== want.held) begin
            $error("tracks_held: expected %0d actual %0d", want.held, got.held); errors++;
          end
        end
      end
      if (!stalls_on) begin
        hold_cycles = 0;
        m_axis_tready <= 1'b1;
      end else if (hold_cycles > 0) begin
        hold_cycles--;
        m_axis_tready <= (hold_cycles == 0);
      end else if ($urandom_range(0, 5) == 0) begin
        hold_cycles = $urandom_range(1, 13);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic test_directed();
    send_item(1'b0, 0, 16'h0000, 16'h0000, 16'h0000);
    send_item(1'b0, 0, 16'h0000, 16'h0000, 16'h0000);  // merge
    send_item(1'b0, 1, 16'h0000, 16'h0000, 16'hFFFF);  // merge, two shared
    send_item(1'b0, 5, 16'hFFFF, 16'hFFFF, 16'hFFFF);  // top view
    send_item(1'b0, 31, 16'hFFFF, 16'hFFFF, 16'hFFFF); // saturated base view
    send_item(1'b0, 6, 16'h1234, 16'h5678, 16'h9ABC);  // saturated, no match
    send_item(1'b0, 3, 16'h0001, 16'h0002, 16'h0003);
    send_item(1'b0, 1, 16'h0000, 16'h0001, 16'h0002);  // no match
    send_item(1'b0, 2, 16'h0000, 16'h0009, 16'h0002);
    send_item(1'b0, 2, 16'h0000, 16'h0001, 16'h0009);  // may disagree
    send_item(1'b1, 0, 16'h0000, 16'h0000, 16'h0000);
    send_item(1'b0, 2, 16'hAAAA, 16'h5555, 16'hAAAA);
    send_item(1'b1, 21, 16'hFFFF, 16'hFFFF, 16'hFFFF);
  endtask

  task automatic test_overlap_extremes();
    write_overlap(6'd0);   // every consistent track matches
    for (int k = 0; k < 8; k++)
      send_item(1'b0, $urandom_range(0, 5), 16'($urandom_range(0, 1)),
                16'($urandom_range(0, 1)), 16'($urandom_range(0, 1)));
    write_overlap(6'd63);  // nothing matches
    for (int k = 0; k < 4; k++)
      send_item(1'b0, 0, 16'h0, 16'h0, 16'h0);
    send_item(1'b1, 0, 16'h0, 16'h0, 16'h0);
    write_overlap(6'd3);
    send_item(1'b0, 0, 16'h7, 16'h7, 16'h7);
    send_item(1'b0, 0, 16'h7, 16'h7, 16'h7);
  endtask

  task automatic test_random(input int n, input bit wide);
    int bv;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 29) == 0) begin
        send_item(1'b1, $urandom_range(0, 31), 16'($urandom), 16'($urandom), 16'($urandom));
        continue;
      end
      bv = $urandom_range(0, 10) == 0 ? $urandom_range(0, 31) : $urandom_range(0, 5);
      if (wide)
        send_item(1'b0, bv, 16'($urandom), 16'($urandom), 16'($urandom));
      else
        send_item(1'b0, bv, 16'($urandom_range(0, 2)), 16'($urandom_range(0, 2)),
                  16'($urandom_range(0, 2)));
      if (k == n / 2) drain();  // hold until every result is back
    end
  endtask

  initial begin
    overlap_min = MIN_OVERLAP_RST;
    trk_total = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_overlap_extremes();
    write_overlap(6'd1);
    test_random(30, 1'b0);
    write_overlap(6'd2);
    test_random(20, 1'b0);
    test_random(10, 1'b1);
    stalls_on = 1'b0;
    test_random(20, 1'b0);
    drain();
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/wtm_pkg.sv
hw/rtl/wtm_store.sv
hw/rtl/wildcard_track_merge_table.sv
sim/tb_top.sv
